@@ rtl/causal_fir_convolution_defines.svh @@
// ----------------------------------------------------------------------------
// causal_fir_convolution_defines.svh
// Assertion macros for the FIR convolution block.
// Each macro expects i_clk and i_rst_n in scope and disables during reset.
// ----------------------------------------------------------------------------
`ifndef CAUSAL_FIR_CONVOLUTION_DEFINES_SVH
`define CAUSAL_FIR_CONVOLUTION_DEFINES_SVH

`ifndef SYNTHESIS

// prop must hold at every clock edge outside reset
`define CFC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// expr must never be true outside reset
`define CFC_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error(msg);

`else

`define CFC_ASSERT(label, prop, msg)
`define CFC_ASSERT_NEVER(label, expr, msg)

`endif

`endif

@@ rtl/cfc_pkg.sv @@
// ----------------------------------------------------------------------------
// cfc_pkg
// Types and fixed constants of the causal FIR convolution block.
// ----------------------------------------------------------------------------
package cfc_pkg;

    // field widths
    localparam int SAMPLE_W  = 24;
    localparam int COEF_W    = 16;
    localparam int CIDX_W    = 7;
    localparam int TAPCNT_W  = 8;
    localparam int OUT_W     = 32;
    localparam int PROD_W    = SAMPLE_W + COEF_W;
    localparam int FRAC_BITS = 15;

    // input tdata layout, lowest bit first
    localparam int SMP_LSB   = 0;
    localparam int CIDX_LSB  = SMP_LSB + SAMPLE_W;
    localparam int CVAL_LSB  = CIDX_LSB + CIDX_W;
    localparam int IN_USED_W = CVAL_LSB + COEF_W;
    localparam int IN_DATA_W = ((IN_USED_W + 7) / 8) * 8;

    // input tuser layout
    localparam int USER_W    = 2;
    localparam int U_REQ     = 0;
    localparam int U_FIRST   = 1;

    // request kinds
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_COEF   = 1'b1;

    // reset value of the tap count register
    localparam logic [TAPCNT_W-1:0] TAP_COUNT_RST = 8'd128;

    // rounding and saturation
    localparam longint ROUND_HALF = 64'sd16384;
    localparam longint OUT_MAX    = 64'sd2147483647;
    localparam longint OUT_MIN    = -64'sd2147483648;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_FINISH
    } t_state;

endpackage

@@ rtl/causal_fir_convolution.sv @@
// ----------------------------------------------------------------------------
// causal_fir_convolution
// Direct-form FIR filter with one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// For each accepted sample the single multiply-accumulate unit walks avail
// taps, where avail is the smaller of the tap count (clamped to MAX_TAPS)
// and the number of samples seen so far in the current waveform, this one
// included. It takes one tap per cycle from the coefficient and history
// memories (one read port each), followed by the memory read, multiply and
// round/saturate stages. With no tap active the walk is skipped. The
// sequencer then waits for the read and multiply registers to drain and
// loads the result once the output register is free. The input is ready
// again in the cycle after the load, and not while a sample is in work. A
// coefficient write gives no result. A finished result waits in an output
// register, so the next transaction may be accepted before it is taken.
// Coefficients must be written before use; there is no clearing pass
// after reset.
// ----------------------------------------------------------------------------
module causal_fir_convolution #(
    parameter int MAX_TAPS = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // tap count register
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,

    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [23:0] sample_value, [30:24] coef_index, [46:31] coef_value, [47] zero
    input  logic [47:0] s_axis_tdata,
    // [0] req_type, [1] first_of_waveform
    input  logic [1:0]  s_axis_tuser,
    input  logic        s_axis_tlast,   // last_of_waveform

    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] filtered_value
    output logic [31:0] m_axis_tdata,
    output logic        m_axis_tlast    // end_of_waveform
);

`include "causal_fir_convolution_defines.svh"

    localparam int ADDR_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int SEEN_W = $clog2(MAX_TAPS + 1);
    localparam int CMP_W  = (SEEN_W > cfc_pkg::TAPCNT_W) ? SEEN_W : cfc_pkg::TAPCNT_W;
    localparam int ACC_W  = cfc_pkg::PROD_W + SEEN_W + 1;

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    cfc_pkg::t_state r_state, n_state;

    logic [cfc_pkg::TAPCNT_W-1:0] r_tap_count;
    logic [ADDR_W-1:0]            r_hptr;
    logic [SEEN_W-1:0]            r_seen;
    logic [SEEN_W-1:0]            r_avail;
    logic [ADDR_W-1:0]            r_k;
    logic [ADDR_W-1:0]            r_rd_ptr;
    logic                         r_last;
    logic                         r_v1;
    logic                         r_v2;

    logic signed [cfc_pkg::COEF_W-1:0]   r_coef_q;
    logic signed [cfc_pkg::SAMPLE_W-1:0] r_hist_q;
    logic signed [cfc_pkg::PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]             r_acc;

    logic                         r_out_valid;
    logic [cfc_pkg::OUT_W-1:0]    r_out_data;
    logic                         r_out_last;

    // memories
    logic signed [cfc_pkg::COEF_W-1:0]   r_coef_mem [MAX_TAPS];
    logic signed [cfc_pkg::SAMPLE_W-1:0] r_hist_mem [MAX_TAPS];

    // ------------------------------------------------------------------
    // input field decode
    // ------------------------------------------------------------------
    logic                                w_req;
    logic                                w_first;
    logic signed [cfc_pkg::SAMPLE_W-1:0] w_sample;
    logic [cfc_pkg::CIDX_W-1:0]          w_cidx;
    logic signed [cfc_pkg::COEF_W-1:0]   w_cval;

    assign w_req    = s_axis_tuser[cfc_pkg::U_REQ];
    assign w_first  = s_axis_tuser[cfc_pkg::U_FIRST];
    assign w_sample = s_axis_tdata[cfc_pkg::SMP_LSB +: cfc_pkg::SAMPLE_W];
    assign w_cidx   = s_axis_tdata[cfc_pkg::CIDX_LSB +: cfc_pkg::CIDX_W];
    assign w_cval   = s_axis_tdata[cfc_pkg::CVAL_LSB +: cfc_pkg::COEF_W];

    // ------------------------------------------------------------------
    // control outputs of the sequencer
    // ------------------------------------------------------------------
    logic w_accept;
    logic w_smp_acc;
    logic w_coef_wr;
    logic w_issue;
    logic w_last_issue;
    logic w_slot_free;
    logic w_out_load;

    always_comb begin
        s_axis_tready = (r_state == cfc_pkg::ST_IDLE);
        w_issue       = (r_state == cfc_pkg::ST_MAC);
        w_out_load    = (r_state == cfc_pkg::ST_FINISH) && w_slot_free;
    end

    assign w_accept     = s_axis_tvalid && s_axis_tready;
    assign w_smp_acc    = w_accept && (w_req == cfc_pkg::REQ_SAMPLE);
    assign w_coef_wr    = w_accept && (w_req == cfc_pkg::REQ_COEF)
                          && (32'(w_cidx) < 32'(MAX_TAPS));
    assign w_last_issue = (SEEN_W'(r_k) + SEEN_W'(1)) == r_avail;
    assign w_slot_free  = !r_out_valid || m_axis_tready;

    // ------------------------------------------------------------------
    // waveform bookkeeping for an accepted sample
    // ------------------------------------------------------------------
    logic [SEEN_W-1:0] w_seen0;
    logic [SEEN_W-1:0] w_seen1;
    logic [CMP_W-1:0]  w_taps;
    logic [SEEN_W-1:0] w_avail;

    always_comb begin
        w_seen0 = w_first ? '0 : r_seen;
        w_seen1 = (w_seen0 < SEEN_W'(MAX_TAPS)) ? w_seen0 + SEEN_W'(1) : w_seen0;
        w_taps  = (CMP_W'(r_tap_count) > CMP_W'(MAX_TAPS)) ? CMP_W'(MAX_TAPS)
                                                           : CMP_W'(r_tap_count);
        w_avail = (w_taps < CMP_W'(w_seen1)) ? SEEN_W'(w_taps) : w_seen1;
    end

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            cfc_pkg::ST_IDLE: begin
                if (w_smp_acc) begin
                    n_state = (w_avail == '0) ? cfc_pkg::ST_DRAIN : cfc_pkg::ST_MAC;
                end
            end
            cfc_pkg::ST_MAC: begin
                if (w_last_issue) begin
                    n_state = cfc_pkg::ST_DRAIN;
                end
            end
            cfc_pkg::ST_DRAIN: begin
                if (!r_v1 && !r_v2) begin
                    n_state = cfc_pkg::ST_FINISH;
                end
            end
            cfc_pkg::ST_FINISH: begin
                if (w_slot_free) begin
                    n_state = cfc_pkg::ST_IDLE;
                end
            end
            default: n_state = cfc_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cfc_pkg::ST_IDLE;
            r_tap_count <= cfc_pkg::TAP_COUNT_RST;
            r_hptr      <= '0;
            r_seen      <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= w_issue;
            r_v2    <= r_v1;
            if (i_cfg_wr_en) begin
                r_tap_count <= i_cfg_wr_data;
            end
            if (w_smp_acc) begin
                r_hptr <= (r_hptr == ADDR_W'(MAX_TAPS - 1)) ? '0 : r_hptr + ADDR_W'(1);
                r_seen <= s_axis_tlast ? '0 : w_seen1;
            end
        end
    end

    // ------------------------------------------------------------------
    // tap walk: tap index up, history pointer down with wrap
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_smp_acc) begin
            r_k      <= '0;
            r_rd_ptr <= r_hptr;
            r_avail  <= w_avail;
            r_last   <= s_axis_tlast;
        end else if (w_issue) begin
            r_k      <= r_k + ADDR_W'(1);
            r_rd_ptr <= (r_rd_ptr == '0) ? ADDR_W'(MAX_TAPS - 1) : r_rd_ptr - ADDR_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // coefficient memory
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_coef_wr) begin
            r_coef_mem[ADDR_W'(w_cidx)] <= w_cval;
        end
        r_coef_q <= r_coef_mem[r_k];
    end

    // ------------------------------------------------------------------
    // sample history memory
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_smp_acc) begin
            r_hist_mem[r_hptr] <= w_sample;
        end
        r_hist_q <= r_hist_mem[r_rd_ptr];
    end

    // ------------------------------------------------------------------
    // shared multiply-accumulate
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_prod <= r_coef_q * r_hist_q;
        if (w_smp_acc) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // ------------------------------------------------------------------
    // round half up from Q.15, then saturate to 32 bits
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0]   w_rnd;
    logic [cfc_pkg::OUT_W-1:0] w_sat;

    always_comb begin
        w_rnd = (r_acc + ACC_W'(cfc_pkg::ROUND_HALF)) >>> cfc_pkg::FRAC_BITS;
        if (w_rnd > ACC_W'(cfc_pkg::OUT_MAX)) begin
            w_sat = cfc_pkg::OUT_W'(cfc_pkg::OUT_MAX);
        end else if (w_rnd < ACC_W'(cfc_pkg::OUT_MIN)) begin
            w_sat = cfc_pkg::OUT_W'(cfc_pkg::OUT_MIN);
        end else begin
            w_sat = w_rnd[cfc_pkg::OUT_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data <= w_sat;
            r_out_last <= r_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `CFC_ASSERT(a_idle_pipe_empty, s_axis_tready |-> (!r_v1 && !r_v2), "MAC busy while ready")
    `CFC_ASSERT(a_issue_in_range, w_issue |-> (SEEN_W'(r_k) < r_avail), "tap past active count")
    `CFC_ASSERT_NEVER(a_seen_bound, r_seen > SEEN_W'(MAX_TAPS), "sample count above limit")

endmodule
